### sv/dpb_pkg.sv
`default_nettype none
package dpb_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_SCALE = 3'd0,
        CFG_CENTER_X    = 3'd1,
        CFG_CENTER_Y    = 3'd2,
        CFG_FOCAL_X     = 3'd3,
        CFG_FOCAL_Y     = 3'd4,
        CFG_OBST_INT    = 3'd5
    } t_cfg_idx;

    localparam logic [7:0]  GRAY_LEVEL = 8'd102;
    localparam logic [15:0] RST_DEPTH_SCALE = 16'd1000;
    localparam logic [15:0] RST_CENTER_X = 16'd7597;
    localparam logic [15:0] RST_CENTER_Y = 16'd3985;
    localparam logic [15:0] RST_FOCAL_X = 16'd8375;
    localparam logic [15:0] RST_FOCAL_Y = 16'd8390;
    localparam logic [7:0]  RST_OBST_INT = 8'd20;
    localparam logic [15:0] MIN_FOCAL = 16'd16;

    localparam logic POINT_OBJECT = 1'b0;
    localparam logic POINT_OBSTACLE = 1'b1;

    typedef struct packed {
        logic [15:0] depth_scale;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] focal_x;
        logic [15:0] focal_y;
    } t_geom;

    // one queued point job
    typedef struct packed {
        logic        point_class;
        logic [11:0] row;
        logic [11:0] col;
        logic [15:0] depth;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_entry;

endpackage
`default_nettype wire

### sv/dpb_front.sv
`default_nettype none
module dpb_front
    import dpb_pkg::*;
#(
    parameter int unsigned MAX_COLS = 4096,
    parameter int unsigned MAX_ROWS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_frame_start,
    input  wire logic [11:0] i_pixel_row,
    input  wire logic [11:0] i_pixel_col,
    input  wire logic [15:0] i_depth_raw,
    input  wire logic [7:0]  i_mask_value,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_obstacle_interval,
    output logic             o_push,
    output t_entry           o_push_data
);

    logic [7:0] r_skip;
    logic [7:0] n_skip;
    logic [7:0] base;
    logic [7:0] inc;
    logic       live;

    always_comb begin
        base = i_frame_start ? 8'd0 : r_skip;
        inc = base + 8'd1;
        live = (i_depth_raw != 16'd0) && ({1'b0, i_pixel_row} < 13'(MAX_ROWS))
            && ({1'b0, i_pixel_col} < 13'(MAX_COLS));
        n_skip = r_skip;
        o_push = 1'b0;
        o_push_data.point_class = POINT_OBJECT;
        o_push_data.row = i_pixel_row;
        o_push_data.col = i_pixel_col;
        o_push_data.depth = i_depth_raw;
        o_push_data.red = i_red_in;
        o_push_data.green = i_green_in;
        o_push_data.blue = i_blue_in;
        if (i_accept) begin
            n_skip = base;
            if (live) begin
                if (i_mask_value != 8'd0) begin
                    o_push = 1'b1;
                end else if (inc == i_obstacle_interval) begin
                    n_skip = 8'd0;
                    o_push = 1'b1;
                    o_push_data.point_class = POINT_OBSTACLE;
                    o_push_data.red = GRAY_LEVEL;
                    o_push_data.green = GRAY_LEVEL;
                    o_push_data.blue = GRAY_LEVEL;
                end else begin
                    n_skip = inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 8'd0;
        end else begin
            r_skip <= n_skip;
        end
    end

endmodule
`default_nettype wire

### sv/dpb_fifo.sv
`default_nettype none
module dpb_fifo
    import dpb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_data,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_nempty,
    output t_entry      o_data
);

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_nempty = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

### sv/dpb_back.sv
`default_nettype none
module dpb_back
    import dpb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_geom            i_geom,
    input  wire logic        i_q_nempty,
    input  t_entry           i_q_data,
    output logic             o_q_pop,
    input  wire logic        i_stall,
    output logic             o_valid,
    output logic             o_point_class,
    output logic [45:0]      o_coord_x,
    output logic [45:0]      o_coord_y,
    output logic [31:0]      o_coord_z,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ZDIV = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_XYDIV = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state      r_state;
    t_entry      r_ent;
    logic [5:0]  r_cnt;
    logic [31:0] r_zq;
    logic [15:0] r_zr;
    logic [31:0] r_z;
    logic [47:0] r_xq;
    logic [15:0] r_xr;
    logic [47:0] r_yq;
    logic [15:0] r_yr;
    logic        r_xneg;
    logic        r_yneg;

    logic [15:0] scale;
    logic [15:0] div_x;
    logic [15:0] div_y;
    logic [15:0] p16x;
    logic [15:0] p16y;
    logic        negx;
    logic        negy;
    logic [15:0] magx;
    logic [15:0] magy;
    logic [16:0] zsh;
    logic        zge;
    logic [16:0] xsh;
    logic        xge;
    logic [16:0] ysh;
    logic        yge;
    logic [47:0] xneg_q;
    logic [47:0] yneg_q;
    logic        out_free;

    always_comb begin
        scale = (i_geom.depth_scale == 16'd0) ? 16'd1 : i_geom.depth_scale;
        div_x = (i_geom.focal_x < MIN_FOCAL) ? MIN_FOCAL : i_geom.focal_x;
        div_y = (i_geom.focal_y < MIN_FOCAL) ? MIN_FOCAL : i_geom.focal_y;
        p16x = {r_ent.col, 4'b0000};
        p16y = {r_ent.row, 4'b0000};
        negx = p16x < i_geom.center_x;
        negy = p16y < i_geom.center_y;
        magx = negx ? (i_geom.center_x - p16x) : (p16x - i_geom.center_x);
        magy = negy ? (i_geom.center_y - p16y) : (p16y - i_geom.center_y);
        zsh = {r_zr, r_zq[31]};
        zge = zsh >= {1'b0, scale};
        xsh = {r_xr, r_xq[47]};
        xge = xsh >= {1'b0, div_x};
        ysh = {r_yr, r_yq[47]};
        yge = ysh >= {1'b0, div_y};
        xneg_q = ~r_xq + 48'd1;
        yneg_q = ~r_yq + 48'd1;
        out_free = !o_valid || !i_stall;
        o_q_pop = (r_state == ST_IDLE) && i_q_nempty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && out_free) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_nempty) begin
                        r_state <= ST_ZDIV;
                    end
                end
                ST_ZDIV: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_XYDIV;
                end
                ST_XYDIV: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // shift-subtract dividers, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ent <= i_q_data;
                r_zq <= {i_q_data.depth, 16'd0};
                r_zr <= 16'd0;
                r_cnt <= 6'd31;
            end
            ST_ZDIV: begin
                r_zr <= zge ? 16'(zsh - {1'b0, scale}) : zsh[15:0];
                r_zq <= {r_zq[30:0], zge};
                r_cnt <= r_cnt - 6'd1;
            end
            ST_MUL: begin
                r_z <= r_zq;
                r_xq <= 48'(magx) * 48'(r_zq);
                r_yq <= 48'(magy) * 48'(r_zq);
                r_xr <= 16'd0;
                r_yr <= 16'd0;
                r_xneg <= negx;
                r_yneg <= negy;
                r_cnt <= 6'd47;
            end
            ST_XYDIV: begin
                r_xr <= xge ? 16'(xsh - {1'b0, div_x}) : xsh[15:0];
                r_xq <= {r_xq[46:0], xge};
                r_yr <= yge ? 16'(ysh - {1'b0, div_y}) : ysh[15:0];
                r_yq <= {r_yq[46:0], yge};
                r_cnt <= r_cnt - 6'd1;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_point_class <= r_ent.point_class;
                    o_coord_x <= r_xneg ? xneg_q[45:0] : r_xq[45:0];
                    o_coord_y <= r_yneg ? yneg_q[45:0] : r_yq[45:0];
                    o_coord_z <= r_z;
                    o_red_out <= r_ent.red;
                    o_green_out <= r_ent.green;
                    o_blue_out <= r_ent.blue;
                end
            end
            default: begin
                r_cnt <= 6'd0;
            end
        endcase
    end

endmodule
`default_nettype wire

### sv/depth_pixel_backprojection_split_unit.sv
// Pixels that give no point end at the front; a point waits in a two-word queue.
// Each point holds the back end through load, z divide, multiply, x/y divide and the
// output register; the next point is taken only after that, and an output stall holds it longer.
// With an idle queue and back end, an accepted point passes the queue and those steps, then o_valid rises.
// Reset (synchronous, active low) loads register defaults, clears the obstacle
// counter, empties the queue and drops the output word.
`default_nettype none
module depth_pixel_backprojection_split_unit
    import dpb_pkg::*;
#(
    parameter int unsigned MAX_COLS = 4096,
    parameter int unsigned MAX_ROWS = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_frame_start,
    input  wire logic [11:0]           i_pixel_row,
    input  wire logic [11:0]           i_pixel_col,
    input  wire logic [15:0]           i_depth_raw,
    input  wire logic [7:0]            i_mask_value,
    input  wire logic [7:0]            i_blue_in,
    input  wire logic [7:0]            i_green_in,
    input  wire logic [7:0]            i_red_in,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_point_class,
    output logic [45:0]                o_coord_x,
    output logic [45:0]                o_coord_y,
    output logic [31:0]                o_coord_z,
    output logic [7:0]                 o_red_out,
    output logic [7:0]                 o_green_out,
    output logic [7:0]                 o_blue_out
);

    t_geom      r_geom;
    logic [7:0] r_obst_int;
    logic       full;
    logic       nempty;
    logic       push;
    logic       pop;
    t_entry     push_data;
    t_entry     head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.depth_scale <= RST_DEPTH_SCALE;
            r_geom.center_x <= RST_CENTER_X;
            r_geom.center_y <= RST_CENTER_Y;
            r_geom.focal_x <= RST_FOCAL_X;
            r_geom.focal_y <= RST_FOCAL_Y;
            r_obst_int <= RST_OBST_INT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEPTH_SCALE: r_geom.depth_scale <= i_cfg_data;
                CFG_CENTER_X:    r_geom.center_x <= i_cfg_data;
                CFG_CENTER_Y:    r_geom.center_y <= i_cfg_data;
                CFG_FOCAL_X:     r_geom.focal_x <= i_cfg_data;
                CFG_FOCAL_Y:     r_geom.focal_y <= i_cfg_data;
                CFG_OBST_INT:    r_obst_int <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_stall = full;

    dpb_front #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(i_valid && !full),
        .i_frame_start(i_frame_start),
        .i_pixel_row(i_pixel_row),
        .i_pixel_col(i_pixel_col),
        .i_depth_raw(i_depth_raw),
        .i_mask_value(i_mask_value),
        .i_blue_in(i_blue_in),
        .i_green_in(i_green_in),
        .i_red_in(i_red_in),
        .i_obstacle_interval(r_obst_int),
        .o_push(push),
        .o_push_data(push_data)
    );

    dpb_fifo u_fifo (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_data(push_data),
        .i_pop(pop),
        .o_full(full),
        .o_nempty(nempty),
        .o_data(head)
    );

    dpb_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_geom(r_geom),
        .i_q_nempty(nempty),
        .i_q_data(head),
        .o_q_pop(pop),
        .i_stall(i_stall),
        .o_valid(o_valid),
        .o_point_class(o_point_class),
        .o_coord_x(o_coord_x),
        .o_coord_y(o_coord_y),
        .o_coord_z(o_coord_z),
        .o_red_out(o_red_out),
        .o_green_out(o_green_out),
        .o_blue_out(o_blue_out)
    );

endmodule
`default_nettype wire

### test/tb_depth_pixel_backprojection_split_unit.sv
`default_nettype none
module tb_depth_pixel_backprojection_split_unit;
    import dpb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic        frame_start;
        logic [11:0] row;
        logic [11:0] col;
        logic [15:0] depth;
        logic [7:0]  mask;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_pixel;

    typedef struct {
        logic        point_class;
        logic [45:0] x;
        logic [45:0] y;
        logic [31:0] z;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_frame_start = 1'b0;
    logic [11:0] i_pixel_row = '0;
    logic [11:0] i_pixel_col = '0;
    logic [15:0] i_depth_raw = '0;
    logic [7:0] i_mask_value = '0;
    logic [7:0] i_blue_in = '0;
    logic [7:0] i_green_in = '0;
    logic [7:0] i_red_in = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    logic o_point_class;
    logic [45:0] o_coord_x;
    logic [45:0] o_coord_y;
    logic [31:0] o_coord_z;
    logic [7:0] o_red_out;
    logic [7:0] o_green_out;
    logic [7:0] o_blue_out;

    depth_pixel_backprojection_split_unit DUT (.*);

    always #1 i_clk = ~i_clk;

    // shadow of the block's registers and decimation counter
    logic [15:0] depth_scale, center_x, center_y, focal_x, focal_y;
    logic [7:0]  obst_interval;
    logic [7:0]  skip_cnt;

    t_pixel pixel_q[$];
    t_point point_q[$];
    int     mismatches = 0;
    bit     quiet = 0;
    bit     long_hold_req = 0;
    bit     pixel_taken = 0;
    bit     point_taken = 0;
    int     tx_wait = 0;
    int     rx_wait = 0;
    int     rx_long = 0;
    int     idle_cycles = 0;

    function automatic int draw_wait();
        if (quiet || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [45:0] project(logic [11:0] pos, logic [15:0] ctr,
                                            logic [15:0] foc, logic [31:0] z);
        longint unsigned p16, mag, dv, q;
        bit neg;
        p16 = 64'(pos) * 16;
        neg = p16 < 64'(ctr);
        mag = neg ? 64'(ctr) - p16 : p16 - 64'(ctr);
        dv = (foc < MIN_FOCAL) ? 64'(MIN_FOCAL) : 64'(foc);
        q = (mag * 64'(z)) / dv;
        if (neg) q = -q;
        return q[45:0];
    endfunction

    // advance the counter and return 1 with the point if the pixel makes one
    function automatic bit backproject(t_pixel px, output t_point pt);
        longint unsigned scale, zz;
        bit obstacle;
        if (px.frame_start) skip_cnt = '0;
        if (px.depth == 0) return 0;
        obstacle = 0;
        if (px.mask == 0) begin
            skip_cnt = skip_cnt + 8'd1;
            if (skip_cnt != obst_interval) return 0;
            skip_cnt = '0;
            obstacle = 1;
        end
        scale = (depth_scale == 0) ? 1 : 64'(depth_scale);
        zz = (64'(px.depth) << 16) / scale;
        pt.point_class = obstacle ? POINT_OBSTACLE : POINT_OBJECT;
        pt.z = zz[31:0];
        pt.x = project(px.col, center_x, focal_x, pt.z);
        pt.y = project(px.row, center_y, focal_y, pt.z);
        pt.red = obstacle ? GRAY_LEVEL : px.red;
        pt.green = obstacle ? GRAY_LEVEL : px.green;
        pt.blue = obstacle ? GRAY_LEVEL : px.blue;
        return 1;
    endfunction

    // accept side: predict at the edge the pixel is taken
    always @(posedge i_clk) begin
        t_point pt;
        t_pixel px;
        pixel_taken <= i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            px.frame_start = i_frame_start;
            px.row = i_pixel_row;
            px.col = i_pixel_col;
            px.depth = i_depth_raw;
            px.mask = i_mask_value;
            px.blue = i_blue_in;
            px.green = i_green_in;
            px.red = i_red_in;
            if (backproject(px, pt)) point_q = {point_q, pt};
        end
    end

    // pixel driver
    always @(negedge i_clk) begin
        t_pixel px;
        if (i_rst_n && (!i_valid || pixel_taken)) begin
            if (tx_wait > 0) begin
                tx_wait <= tx_wait - 1;
                i_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                px = pixel_q.pop_front();
                i_frame_start <= px.frame_start;
                i_pixel_row <= px.row;
                i_pixel_col <= px.col;
                i_depth_raw <= px.depth;
                i_mask_value <= px.mask;
                i_blue_in <= px.blue;
                i_green_in <= px.green;
                i_red_in <= px.red;
                i_valid <= 1'b1;
                tx_wait <= draw_wait();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // point monitor
    always @(posedge i_clk) begin
        t_point pt;
        point_taken <= o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (point_q.size() == 0) begin
                $error("point word with no pending expectation");
                mismatches++;
            end else begin
                pt = point_q.pop_front();
                if (o_point_class !== pt.point_class) begin
                    $error("point_class: expected %0d, got %0d", pt.point_class, o_point_class);
                    mismatches++;
                end
                if (o_coord_x !== pt.x) begin
                    $error("coord_x: expected %0d, got %0d", $signed(pt.x), $signed(o_coord_x));
                    mismatches++;
                end
                if (o_coord_y !== pt.y) begin
                    $error("coord_y: expected %0d, got %0d", $signed(pt.y), $signed(o_coord_y));
                    mismatches++;
                end
                if (o_coord_z !== pt.z) begin
                    $error("coord_z: expected %0d, got %0d", pt.z, o_coord_z);
                    mismatches++;
                end
                if (o_red_out !== pt.red) begin
                    $error("red_out: expected %0d, got %0d", pt.red, o_red_out);
                    mismatches++;
                end
                if (o_green_out !== pt.green) begin
                    $error("green_out: expected %0d, got %0d", pt.green, o_green_out);
                    mismatches++;
                end
                if (o_blue_out !== pt.blue) begin
                    $error("blue_out: expected %0d, got %0d", pt.blue, o_blue_out);
                    mismatches++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        int w;
        w = point_taken ? draw_wait() : rx_wait;
        if (long_hold_req && rx_long == 0) begin
            rx_long = LONG_HOLD;
            long_hold_req = 0;
        end
        if (rx_long > 0) begin
            rx_long = rx_long - 1;
            i_stall <= 1'b1;
        end else if (w > 0) begin
            rx_wait = w - 1;
            i_stall <= 1'b1;
        end else begin
            rx_wait = 0;
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_DEPTH_SCALE: depth_scale = val;
            CFG_CENTER_X:    center_x = val;
            CFG_CENTER_Y:    center_y = val;
            CFG_FOCAL_X:     focal_x = val;
            CFG_FOCAL_Y:     focal_y = val;
            CFG_OBST_INT:    obst_interval = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_geom(logic [15:0] sc, logic [15:0] cx, logic [15:0] cy,
                              logic [15:0] fx, logic [15:0] fy, logic [15:0] oi);
        write_reg(CFG_DEPTH_SCALE, sc);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_OBST_INT, oi);
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || i_valid || point_q.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic add_pixel(logic fs, logic [11:0] r, logic [11:0] c, logic [15:0] d,
                             logic [7:0] m, logic [7:0] b, logic [7:0] g, logic [7:0] rd);
        t_pixel px;
        px.frame_start = fs;
        px.row = r;
        px.col = c;
        px.depth = d;
        px.mask = m;
        px.blue = b;
        px.green = g;
        px.red = rd;
        pixel_q = {pixel_q, px};
    endtask

    task automatic add_random(int n);
        logic [15:0] d;
        logic [7:0] m;
        repeat (n) begin
            case ($urandom_range(0, 7))
                0: d = '0;
                1: d = 16'hFFFF;
                2: d = 16'($urandom_range(1, 255));
                default: d = 16'($urandom);
            endcase
            m = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
            add_pixel($urandom_range(0, 31) == 0, 12'($urandom), 12'($urandom), d, m,
                      8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 32));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        depth_scale = RST_DEPTH_SCALE;
        center_x = RST_CENTER_X;
        center_y = RST_CENTER_Y;
        focal_x = RST_FOCAL_X;
        focal_y = RST_FOCAL_Y;
        obst_interval = RST_OBST_INT;
        skip_cnt = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: extremes of the pixel fields
        add_pixel(1, 0, 0, 16'hFFFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
        add_pixel(0, 12'hFFF, 12'hFFF, 16'hFFFF, 8'h01, 8'hFF, 8'h00, 8'hFF);
        add_pixel(0, 12'hFFF, 0, 16'd1, 8'h80, 8'h55, 8'hAA, 8'h5A);
        add_pixel(1, 0, 12'hFFF, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_pixel(0, 249, 474, 16'd1500, 8'h7F, 8'h12, 8'h34, 8'h56);
        drain();

        // tiny interval: obstacle every other unmasked pixel, zero depth does not count
        write_geom(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd2);
        add_pixel(0, 12'hFFF, 12'hFFF, 16'hFFFF, 0, 1, 2, 3);
        add_pixel(0, 12'd7, 12'd9, 16'h0000, 0, 1, 2, 3);
        add_pixel(0, 0, 0, 16'hFFFF, 0, 1, 2, 3);
        add_pixel(0, 5, 5, 16'd100, 0, 4, 5, 6);
        add_pixel(1, 6, 6, 16'd0, 0, 4, 5, 6);
        add_pixel(0, 7, 7, 16'd300, 0, 4, 5, 6);
        add_pixel(0, 8, 8, 16'd300, 8'h01, 4, 5, 6);
        add_pixel(0, 9, 9, 16'd300, 0, 4, 5, 6);
        drain();

        // interval taken from the low byte of the write, then lowered while the count is zero
        write_geom(16'hFFFF, 16'hFFFF, 16'd0, 16'd16, 16'd15, 16'hFF05);
        add_pixel(1, 1, 1, 16'd10, 0, 0, 0, 0);
        repeat (9) add_pixel(0, 12'($urandom), 12'($urandom), 16'hFFFF, 0, 0, 0, 0);
        drain();
        write_reg(CFG_OBST_INT, 16'd3);
        repeat (180) add_pixel(0, 12'($urandom), 12'($urandom), 16'($urandom_range(1, 65535)),
                               0, 0, 0, 0);
        drain();

        // zero interval: an obstacle needs 256 unmasked pixels, more than this run sends
        write_reg(CFG_OBST_INT, 16'd0);
        quiet = 1;
        add_random(120);
        drain();
        quiet = 0;

        // receiver holds off while pixels keep coming
        write_geom(pick16(), pick16(), pick16(), pick16(), pick16(), 16'd1);
        long_hold_req = 1;
        add_random(80);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_geom(pick16(), pick16(), pick16(), pick16(), pick16(),
                       16'($urandom_range(0, 6)));
            quiet = (ph == 2);
            add_random(40);
            // sender pauses until every point is back
            while (pixel_q.size() > 0 || i_valid || point_q.size() > 0) @(negedge i_clk);
            add_random(40);
            drain();
        end

        if (mismatches == 0 && point_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
